>>> sv/sidc_pkg.sv
// Package for the signed integer to decimal ASCII unit.
// Holds the control struct of the digit chain, character codes and sizing helpers.
// No dependencies.
package sidc_pkg;

    // Default operand width
    localparam int VALUE_BITS_DEF = 32;

    // ASCII codes, truncated to the six bits carried on the output
    localparam logic [5:0] DIGIT_BASE = 6'd48;
    localparam logic [5:0] MINUS_CHAR = 6'd45;

    // Control shared by all cells of the digit chain
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // add-3 adjust, then shift one binary bit in
        logic move;    // take the lower neighbor's digit
    } sidc_ctrl_t;

    // Number of decimal digits of the largest magnitude, 2**(bits-1)
    function automatic int dec_digits(input int bits);
        logic [64:0] v;
        int          n;
        v = 65'd1 << (bits - 1);
        n = 0;
        for (int i = 0; i < 21; i++)
        begin
            if (v != 65'd0)
            begin
                n = n + 1;
                v = v / 10;
            end
        end
        return n;
    endfunction

endpackage

>>> sv/sidc_digit_cell.sv
// One BCD digit cell of the conversion chain.
// Depends on sidc_pkg for the chain control struct.
module sidc_digit_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  sidc_pkg::sidc_ctrl_t ctl,
    input  logic                shift_in,   // binary bit from the lower neighbor
    input  logic [3:0]          digit_in,   // digit of the lower neighbor
    output logic                carry_out,  // binary bit handed to the upper neighbor
    output logic [3:0]          digit
);
    import sidc_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // Add 3 when the digit would overflow past 9 after doubling
    assign adj       = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign carry_out = adj[3];
    assign digit     = digit_reg;

    // Select the next digit; hold when no command is given
    always_comb
    begin
        digit_next = digit_reg;
        priority if (ctl.clear)
            digit_next = 4'd0;
        else if (ctl.dabble)
            digit_next = {adj[2:0], shift_in};
        else if (ctl.move)
            digit_next = digit_in;
        else
            digit_next = digit_reg;
    end

    // Hold the digit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digit_reg <= 4'd0;
        else
            digit_reg <= digit_next;
    end

endmodule

>>> sv/signed_int_to_decimal_ascii_unit.sv
// Flow: an input transfer clears the digit chain, then the bit-serial double-dabble
// pass runs through it; a minus sign follows if the value is negative, then the chain
// shifts out NDIG digits, one per cycle while the output is not stalled, dropping
// leading zeros without a transfer. A new value is taken only once the last digit is out.
// Reset: rst_n clears the sequencer, the output valid and the digit cells; no other
// state survives items.
module signed_int_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = sidc_pkg::VALUE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // [VALUE_BITS-1:0] value
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [7:0]                              m_tdata,   // [5:0] character
    output logic                                    m_tlast    // last character of the number
);
    import sidc_pkg::*;

    localparam int NDIG  = dec_digits(VALUE_BITS);
    localparam int BIT_W = $clog2(VALUE_BITS);
    localparam int DIG_W = $clog2(NDIG);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SIGN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [BIT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [DIG_W-1:0]        dig_left_reg, dig_left_next;
    logic                    started_reg, started_next;
    logic                    out_valid_reg, out_valid_next;
    logic [5:0]              out_char_reg, out_char_next;
    logic                    out_last_reg, out_last_next;

    logic [VALUE_BITS-1:0]   raw;
    logic                    in_xfer;
    logic                    slot_free;
    logic                    show;
    sidc_ctrl_t              ctl;
    logic [NDIG:0]           carry;
    logic [3:0]              digits [NDIG+1];
    logic [3:0]              top_digit;

    assign raw       = s_tdata[VALUE_BITS-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign top_digit = digits[NDIG];
    // Print once a nonzero digit was seen, or on the units digit
    assign show      = started_reg || (top_digit != 4'd0) || (dig_left_reg == '0);

    // Digit chain: cell 0 is the units digit, binary bits enter there MSB first
    assign carry[0]  = mag_reg[VALUE_BITS-1];
    assign digits[0] = 4'd0;
    for (genvar i = 0; i < NDIG; i++)
    begin : g_cell
        sidc_digit_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .shift_in  (carry[i]),
            .digit_in  (digits[i]),
            .carry_out (carry[i+1]),
            .digit     (digits[i+1])
        );
    end

    // Sequencer and output slot
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_left_next  = dig_left_reg;
        started_next   = started_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ctl            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    neg_next     = raw[VALUE_BITS-1];
                    mag_next     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
                    bit_cnt_next = BIT_W'(VALUE_BITS - 1);
                    ctl.clear    = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // Advance the double-dabble pass by one bit
                ctl.dabble = 1'b1;
                mag_next   = mag_reg << 1;
                if (bit_cnt_reg == '0)
                begin
                    dig_left_next = DIG_W'(NDIG - 1);
                    started_next  = 1'b0;
                    state_next    = neg_reg ? ST_SIGN : ST_EMIT;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = MINUS_CHAR;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Shift digits up; drop leading zeros without a transfer
                if (!show || slot_free)
                begin
                    ctl.move = 1'b1;
                    if (show)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = DIGIT_BASE + {2'b00, top_digit};
                        out_last_next  = (dig_left_reg == '0);
                        started_next   = 1'b1;
                    end
                    if (dig_left_reg == '0)
                        state_next = ST_IDLE;
                    else
                        dig_left_next = dig_left_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_left_reg <= dig_left_next;
        started_reg  <= started_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> sv/sidc_checker.sv
// Port-level checker for the signed integer to decimal ASCII unit, with its bind.
// Depends on sidc_pkg and signed_int_to_decimal_ascii_unit.
module sidc_checker #(
    parameter int VALUE_BITS = sidc_pkg::VALUE_BITS_DEF
) (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    s_tvalid,
    input logic                                    s_tready,
    input logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // [VALUE_BITS-1:0] value
    input logic                                    m_tvalid,
    input logic                                    m_tready,
    input logic [7:0]                              m_tdata,   // [5:0] character
    input logic                                    m_tlast
);
    import sidc_pkg::*;

    // A stalled transfer holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // Only a minus sign or a digit leaves
    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[5:0] == MINUS_CHAR) ||
                     (m_tdata[5:0] >= DIGIT_BASE && m_tdata[5:0] <= DIGIT_BASE + 6'd9))
        else $error("illegal character");

    // A minus sign never ends a number
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5:0] == MINUS_CHAR |-> !m_tlast)
        else $error("minus sign flagged last");

    // Conversion occupies the unit right after an input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken during conversion");

endmodule

bind signed_int_to_decimal_ascii_unit sidc_checker #(.VALUE_BITS(VALUE_BITS)) u_sidc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
